FILE: src/wodr_pkg.sv
// Package for the wheel odometry dead-reckoning block: widths, constants,
// the CORDIC arctangent table and the sequencer state type. No dependencies.
`default_nettype none
package wodr_pkg;

  localparam int CordicStepsDefault = 16;
  localparam int CordicStepsMax     = 32;
  localparam int AngW               = 36;

  localparam logic [15:0] DtLimitReset   = 16'd32768;
  localparam logic [15:0] DtDefaultReset = 16'd3277;
  localparam logic [31:0] NoiseRateReset = 32'd42950;

  localparam logic [1:0] RegDtLimit   = 2'd0;
  localparam logic [1:0] RegDtDefault = 2'd1;
  localparam logic [1:0] RegNoiseRate = 2'd2;

  localparam logic signed [35:0] CordicGainX = 36'sh026DD3B6A;
  localparam logic signed [35:0] QuarterTurn = 36'sh040000000;
  localparam logic signed [35:0] HalfTurn    = 36'sh080000000;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_ATAN  = 7'b0000100,
    ST_ANGLE = 7'b0001000,
    ST_ROT   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2F9;
      5'd15: r = 30'h0000517C;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A2F;
      5'd19: r = 30'h00000517;
      5'd20: r = 30'h0000028B;
      5'd21: r = 30'h00000145;
      5'd22: r = 30'h000000A2;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000028;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000002;
      5'd29: r = 30'h00000001;
      default: r = 30'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/wodr_cordic.sv
// Shared CORDIC micro-rotation unit, used for both vectoring (atan2) and
// rotation (sin/cos). Depends on wodr_pkg for the arctangent table.
`default_nettype none
module wodr_cordic (
  input  wire logic               vectoring_i,
  input  wire logic [4:0]         step_i,
  input  wire logic signed [35:0] x_i,
  input  wire logic signed [35:0] y_i,
  input  wire logic signed [35:0] z_i,
  output logic signed [35:0]      x_o,
  output logic signed [35:0]      y_o,
  output logic signed [35:0]      z_o
);
  logic signed [35:0] dx, dy, at;
  logic               pos;

  always_comb begin
    dx  = y_i >>> step_i;
    dy  = x_i >>> step_i;
    at  = $signed({6'd0, wodr_pkg::atan_entry(step_i)});
    // Vectoring drives y to zero; rotation drives z to zero.
    pos = vectoring_i ? !y_i[35] : !z_i[35];
    if (vectoring_i) begin
      if (pos) begin
        x_o = x_i + dx; y_o = y_i - dy; z_o = z_i + at;
      end else begin
        x_o = x_i - dx; y_o = y_i + dy; z_o = z_i - at;
      end
    end else begin
      if (pos) begin
        x_o = x_i - dx; y_o = y_i + dy; z_o = z_i - at;
      end else begin
        x_o = x_i + dx; y_o = y_i - dy; z_o = z_i + at;
      end
    end
  end
endmodule
`default_nettype wire

FILE: src/wheel_odometry_dead_reckoning.sv
// Top level of the wheel odometry dead-reckoning block: stream ports,
// configuration registers and the sequencer. Depends on wodr_pkg, wodr_cordic.
//
// One odometry sample is taken as one input beat; the block then works alone on it and
// offers one result beat, or none when the stamp repeats the previous one. The heading
// comes from a vectoring CORDIC atan2 of the quaternion, and cos/sin of the rounded
// heading from a rotation CORDIC; both use a single shared micro-rotation unit, one step
// a cycle. A sample passes through the quaternion products, the two CORDIC passes through
// that unit, the angle conversion and a short multiply sequence for the displacements
// and the variance. A degenerate quaternion skips the atan2 pass. A sample that repeats
// the previous stamp is taken and gives no result. The input is not ready again until
// the result beat has been taken. Configuration writes land at once and must only be
// made while the block is idle.
`default_nettype none
module wheel_odometry_dead_reckoning #(
  parameter int CORDIC_STEPS = wodr_pkg::CordicStepsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Configuration writes.
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [31:0]  cfg_data_i,
  // Input stream. tdata from bit 0: stamp[48], speed[16], quat_x, quat_y, quat_z,
  // quat_w [16 each].
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,
  // Output stream. tdata from bit 0: pos_x[32], pos_y[32], yaw_deg[17], step_used[16],
  // variance[48], sequence_res[32], then zero fill.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [183:0]      m_axis_tdata
);
  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  logic [15:0] dt_limit_q, dt_default_q;
  logic [31:0] noise_rate_q;

  logic [47:0] last_stamp_q, variance_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [31:0] count_q;

  wodr_pkg::state_e state_q;
  logic [StepW-1:0] step_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic signed [35:0] nx, ny, nz;
  logic signed [15:0] speed_q, qx_q, qy_q, qz_q, qw_q;
  logic [15:0] dt_q;
  logic signed [16:0] yaw_q;
  logic               neg_q;
  logic [2:0]         mstep_q;
  logic signed [63:0] prod_q;
  logic signed [47:0] cs_sp_q;
  logic [183:0]       out_q;

  // Accept and sequencing.
  assign s_axis_tready = (state_q == wodr_pkg::ST_IDLE) && !m_axis_tvalid;
  assign m_axis_tvalid = (state_q == wodr_pkg::ST_OUT);
  assign m_axis_tdata  = out_q;

  wodr_cordic u_cordic (
    .vectoring_i (state_q == wodr_pkg::ST_ATAN),
    .step_i      (5'(step_q)),
    .x_i         (cx_q),
    .y_i         (cy_q),
    .z_i         (cz_q),
    .x_o         (nx),
    .y_o         (ny),
    .z_o         (nz)
  );

  // Shared multiplier operands, chosen by the multiply step.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = '0; mb = '0;
    case (mstep_q)
      3'd0: begin ma = 33'(qx_q); mb = 33'(qy_q); end
      3'd1: begin ma = 33'(qz_q); mb = 33'(qw_q); end
      3'd2: begin ma = 33'(qy_q); mb = 33'(qy_q); end
      3'd3: begin ma = 33'(qz_q); mb = 33'(qz_q); end
      default: begin ma = '0; mb = '0; end
    endcase
    mp = ma * mb;
  end

  // Second atan2 argument, 1 - 2(y^2 + z^2) in Q2.28.
  logic signed [35:0] bx;
  assign bx = 36'sh010000000 - 36'(prod_q <<< 1);

  logic [47:0] diff;
  assign diff = s_axis_tdata[47:0] - last_stamp_q;

  // Angle post-processing terms.
  logic signed [35:0] ang32, na;
  logic signed [55:0] yprod;
  logic [35:0]        hsum;
  logic signed [15:0] head;
  always_comb begin
    ang32 = 36'(signed'(cz_q[31:0]));
    na    = -ang32;
    yprod = 56'(na) * 56'sd92160 + 56'sh80000000;
    hsum  = 36'(na) + 36'h8000;
    head  = signed'(hsum[31:16]);
  end

  // Position and variance updates.
  logic signed [31:0] tx, ty, tsel;
  logic signed [47:0] tsp;
  logic signed [63:0] dprod;
  logic signed [63:0] full;
  logic signed [63:0] disp;
  logic signed [33:0] newpos;
  logic signed [31:0] satpos;
  logic [47:0]        rdt;
  logic [48:0]        rnd;
  logic [47:0]        vinc;
  logic [48:0]        vsum;
  always_comb begin
    tx     = neg_q ? -cx_q[31:0] : cx_q[31:0];
    ty     = neg_q ? -cy_q[31:0] : cy_q[31:0];
    tsel   = (mstep_q == 3'd0) ? tx : ty;
    tsp    = tsel * speed_q;
    dprod  = cs_sp_q * $signed({1'b0, dt_q});
    full   = prod_q + 64'sh20000000000;
    disp   = full >>> 42;
    newpos = (mstep_q == 3'd5 ? 34'(pos_x_q) : 34'(pos_y_q)) + 34'(signed'(disp[21:0]));
    if (newpos > 34'sh07FFFFFFF)      satpos = 32'sh7FFFFFFF;
    else if (newpos < -34'sh080000000) satpos = 32'sh80000000;
    else                               satpos = newpos[31:0];
    rdt  = noise_rate_q * dt_q;
    rnd  = {1'b0, rdt} + 49'h8000;
    vinc = {15'd0, rnd[48:16]};
    vsum = {1'b0, variance_q} + {1'b0, vinc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_limit_q   <= wodr_pkg::DtLimitReset;
      dt_default_q <= wodr_pkg::DtDefaultReset;
      noise_rate_q <= wodr_pkg::NoiseRateReset;
      last_stamp_q <= '0;
      variance_q   <= '0;
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      count_q      <= '0;
      state_q      <= wodr_pkg::ST_IDLE;
      step_q       <= '0;
      mstep_q      <= '0;
      dt_q         <= '0;
      speed_q      <= '0;
      qx_q         <= '0;
      qy_q         <= '0;
      qz_q         <= '0;
      qw_q         <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      cz_q         <= '0;
      yaw_q        <= '0;
      neg_q        <= 1'b0;
      prod_q       <= '0;
      cs_sp_q      <= '0;
      out_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wodr_pkg::RegDtLimit:   dt_limit_q   <= cfg_data_i[15:0];
          wodr_pkg::RegDtDefault: dt_default_q <= cfg_data_i[15:0];
          wodr_pkg::RegNoiseRate: noise_rate_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        wodr_pkg::ST_IDLE: begin
          if (s_axis_tvalid && s_axis_tready &&
              s_axis_tdata[47:0] != last_stamp_q) begin
            last_stamp_q <= s_axis_tdata[47:0];
            dt_q    <= (diff > 48'(dt_limit_q)) ? dt_default_q : diff[15:0];
            speed_q <= s_axis_tdata[63:48];
            qx_q    <= s_axis_tdata[79:64];
            qy_q    <= s_axis_tdata[95:80];
            qz_q    <= s_axis_tdata[111:96];
            qw_q    <= s_axis_tdata[127:112];
            mstep_q <= '0;
            state_q <= wodr_pkg::ST_PREP;
          end
        end
        wodr_pkg::ST_PREP: begin
          // Four products, then build the atan2 arguments.
          case (mstep_q)
            3'd0: begin prod_q <= 64'(mp); mstep_q <= 3'd1; end
            3'd1: begin prod_q <= prod_q - 64'(mp); mstep_q <= 3'd2; end
            3'd2: begin cy_q <= 36'(prod_q <<< 1); prod_q <= 64'(mp); mstep_q <= 3'd3; end
            3'd3: begin prod_q <= prod_q + 64'(mp); mstep_q <= 3'd4; end
            default: begin
              mstep_q <= '0;
              step_q  <= '0;
              // Degenerate vector and negative-x pre-rotation.
              if (cy_q == 0 && bx == 0) begin
                cz_q    <= '0;
                state_q <= wodr_pkg::ST_ANGLE;
              end else if (bx < 0) begin
                if (!cy_q[35]) begin
                  cx_q <= cy_q;
                  cy_q <= -bx;
                  cz_q <= wodr_pkg::QuarterTurn;
                end else begin
                  cx_q <= -cy_q;
                  cy_q <= bx;
                  cz_q <= -wodr_pkg::QuarterTurn;
                end
                state_q <= wodr_pkg::ST_ATAN;
              end else begin
                cx_q    <= bx;
                cz_q    <= '0;
                state_q <= wodr_pkg::ST_ATAN;
              end
            end
          endcase
        end
        wodr_pkg::ST_ATAN: begin
          cx_q <= nx; cy_q <= ny; cz_q <= nz;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(CORDIC_STEPS - 1)) state_q <= wodr_pkg::ST_ANGLE;
        end
        wodr_pkg::ST_ANGLE: begin
          yaw_q <= yprod[48:32];
          // Fold the heading into a quarter turn either side for rotation.
          cx_q  <= wodr_pkg::CordicGainX;
          cy_q  <= '0;
          step_q <= '0;
          if (36'(head) * 65536 > wodr_pkg::QuarterTurn) begin
            cz_q <= 36'(head) * 65536 - wodr_pkg::HalfTurn; neg_q <= 1'b1;
          end else if (36'(head) * 65536 < -wodr_pkg::QuarterTurn) begin
            cz_q <= 36'(head) * 65536 + wodr_pkg::HalfTurn; neg_q <= 1'b1;
          end else begin
            cz_q <= 36'(head) * 65536; neg_q <= 1'b0;
          end
          state_q <= wodr_pkg::ST_ROT;
        end
        wodr_pkg::ST_ROT: begin
          cx_q <= nx; cy_q <= ny; cz_q <= nz;
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(CORDIC_STEPS - 1)) begin
            state_q <= wodr_pkg::ST_MUL;
            mstep_q <= '0;
          end
        end
        wodr_pkg::ST_MUL: begin
          case (mstep_q)
            3'd0: begin cs_sp_q <= tsp; mstep_q <= 3'd1; end
            3'd1: begin prod_q <= dprod; mstep_q <= 3'd2; end
            3'd2: begin cs_sp_q <= tsp; mstep_q <= 3'd5; end
            3'd5: begin pos_x_q <= satpos;
                        prod_q <= dprod;
                        mstep_q <= 3'd6; end
            default: begin
              pos_y_q <= satpos;
              variance_q <= vsum[48] ? 48'hFFFFFFFFFFFF : vsum[47:0];
              count_q <= count_q + 32'd1;
              out_q <= {7'd0, count_q + 32'd1,
                        vsum[48] ? 48'hFFFFFFFFFFFF : vsum[47:0],
                        dt_q, yaw_q, satpos, pos_x_q};
              state_q <= wodr_pkg::ST_OUT;
            end
          endcase
        end
        wodr_pkg::ST_OUT: begin
          if (m_axis_tready) state_q <= wodr_pkg::ST_IDLE;
        end
        default: state_q <= wodr_pkg::ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
